// File: rtl/core/ssdd_pkg.sv
package ssdd_pkg;

  localparam int unsigned DigitCountDefault = 6;
  localparam int unsigned NumberWidth       = 32;
  localparam int unsigned SelWidth          = 3;
  localparam int unsigned SegWidth          = 8;
  localparam int unsigned BcdWidth          = 4;

  localparam logic [SegWidth-1:0]    SegBlank   = 8'hFF;
  localparam logic [NumberWidth-1:0] Recip10    = 32'hCCCC_CCCD;
  localparam int unsigned            Recip10Sh  = 35;

  typedef enum logic [0:0] {
    OpLoad = 1'b0,
    OpTick = 1'b1
  } op_e;

  typedef logic [NumberWidth-1:0] number_t;
  typedef logic [BcdWidth-1:0]    bcd_t;
  typedef logic [SegWidth-1:0]    seg_t;

  // Quotient by ten through the reciprocal: exact for every 32-bit value.
  function automatic number_t div10(input number_t v);
    logic [2*NumberWidth-1:0] prod;
    prod = {{NumberWidth{1'b0}}, v} * {{NumberWidth{1'b0}}, Recip10};
    return number_t'(prod[2*NumberWidth-1:Recip10Sh]);
  endfunction

  // The remainder is below ten, so four bits of the difference are enough.
  function automatic bcd_t rem10(input number_t v, input number_t q);
    bcd_t q4;
    q4 = q[BcdWidth-1:0];
    return bcd_t'(v[BcdWidth-1:0] - bcd_t'(q4 << 3) - bcd_t'(q4 << 1));
  endfunction

  function automatic seg_t seg_encode(input bcd_t d);
    seg_t s;
    case (d)
      4'd0:    s = 8'hC0;
      4'd1:    s = 8'hF9;
      4'd2:    s = 8'hA4;
      4'd3:    s = 8'hB0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hF8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h90;
      default: s = SegBlank;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/core/ssdd_in_if.sv
interface ssdd_in_if import ssdd_pkg::*; ();
  logic    valid;
  logic    ready;
  op_e     operation;
  number_t number;

  modport source (output valid, output operation, output number, input ready);
  modport sink (input valid, input operation, input number, output ready);
endinterface

// File: rtl/core/ssdd_out_if.sv
interface ssdd_out_if import ssdd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SelWidth-1:0] digit_select;
  seg_t                segments;

  modport source (output valid, output digit_select, output segments, input ready);
  modport sink (input valid, input digit_select, input segments, output ready);
endinterface

// File: rtl/core/seven_segment_decimal_display.sv
// Channel  Dir  Payload                  Beat
// in_i     in   operation, number        load a number or request a scan step
// out_o    out  digit_select, segments   one beat per scan step, none per load
//
// One beat is accepted per cycle while out_o does not back the pipeline up; the beat
// passes an input stage, DIGIT_COUNT divide-by-ten stages (one reciprocal multiply each)
// and the buffer stage. A scan result is registered on out_o from the last divide stage.
// Reset blanks the display buffer and returns the scan to position 0.
// A stalled output holds its beat while empty stages behind it keep filling.
module seven_segment_decimal_display import ssdd_pkg::*; #(
  parameter int unsigned DIGIT_COUNT = DigitCountDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ssdd_in_if.sink    in_i,
  ssdd_out_if.source out_o
);

  localparam int unsigned PosW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  logic [DIGIT_COUNT:0]                valid_q;
  logic [DIGIT_COUNT:0]                adv;
  op_e                                 op_q  [DIGIT_COUNT+1];
  number_t                             val_q [DIGIT_COUNT+1];
  logic [DIGIT_COUNT-1:0][BcdWidth-1:0] dig_q [DIGIT_COUNT+1];

  seg_t                disp_q [DIGIT_COUNT];
  seg_t                disp_d [DIGIT_COUNT];
  logic [PosW-1:0]     scan_pos_q;
  logic                out_valid_q;
  logic [SelWidth-1:0] out_sel_q;
  seg_t                out_seg_q;

  logic in_fire;
  logic load_fire;
  logic tick_fire;

  assign in_fire   = in_i.valid && in_i.ready;
  assign load_fire = adv[DIGIT_COUNT] && (op_q[DIGIT_COUNT] == OpLoad);
  assign tick_fire = adv[DIGIT_COUNT] && (op_q[DIGIT_COUNT] == OpTick);

  always_comb begin
    adv[DIGIT_COUNT] = valid_q[DIGIT_COUNT] &&
                       ((op_q[DIGIT_COUNT] == OpLoad) || !out_valid_q || out_o.ready);
    for (int j = DIGIT_COUNT - 1; j >= 0; j--) begin
      adv[j] = valid_q[j] && (!valid_q[j+1] || adv[j+1]);
    end
  end

  assign in_i.ready = !valid_q[0] || adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (in_fire) begin
      valid_q[0] <= 1'b1;
    end else if (adv[0]) begin
      valid_q[0] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q[0]  <= in_i.operation;
      val_q[0] <= in_i.number;
      dig_q[0] <= '0;
    end
  end

  for (genvar j = 1; j <= DIGIT_COUNT; j++) begin : g_stage
    number_t                              quo;
    bcd_t                                 rem;
    logic [DIGIT_COUNT-1:0][BcdWidth-1:0] dig_d;

    assign quo = div10(val_q[j-1]);
    assign rem = rem10(val_q[j-1], quo);

    always_comb begin
      dig_d      = dig_q[j-1];
      dig_d[j-1] = rem;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j] <= 1'b0;
      end else if (adv[j-1]) begin
        valid_q[j] <= 1'b1;
      end else if (adv[j]) begin
        valid_q[j] <= 1'b0;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[j-1]) begin
        op_q[j]  <= op_q[j-1];
        val_q[j] <= quo;
        dig_q[j] <= dig_d;
      end
    end
  end

  always_comb begin : blank_logic
    logic leading;
    leading = 1'b1;
    for (int k = DIGIT_COUNT - 1; k >= 0; k--) begin
      if (leading && (k > 0) && (dig_q[DIGIT_COUNT][k] == '0)) begin
        disp_d[k] = SegBlank;
      end else begin
        leading   = 1'b0;
        disp_d[k] = seg_encode(dig_q[DIGIT_COUNT][k]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIGIT_COUNT; k++) begin
        disp_q[k] <= SegBlank;
      end
      scan_pos_q <= '0;
    end else begin
      if (load_fire) begin
        disp_q <= disp_d;
      end
      if (tick_fire) begin
        if (scan_pos_q == PosW'(DIGIT_COUNT - 1)) begin
          scan_pos_q <= '0;
        end else begin
          scan_pos_q <= scan_pos_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tick_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_fire) begin
      out_sel_q <= SelWidth'(scan_pos_q);
      out_seg_q <= disp_q[scan_pos_q];
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.digit_select = out_sel_q;
  assign out_o.segments     = out_seg_q;

endmodule

// File: rtl/core/ssdd_checker.sv
module ssdd_checker import ssdd_pkg::*; #(
  parameter int unsigned DIGIT_COUNT = DigitCountDefault
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [SelWidth-1:0] out_digit_select_i,
  input seg_t                out_segments_i
);

  logic                out_fire;
  logic                seen_q;
  logic [SelWidth-1:0] last_sel_q;
  logic [SelWidth-1:0] next_sel;

  assign out_fire = out_valid_i && out_ready_i;
  assign next_sel = (last_sel_q == SelWidth'(DIGIT_COUNT - 1)) ? '0 : last_sel_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= 1'b0;
      last_sel_q <= '0;
    end else if (out_fire) begin
      seen_q     <= 1'b1;
      last_sel_q <= out_digit_select_i;
    end
  end

  a_sel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_digit_select_i < SelWidth'(DIGIT_COUNT)))
    else $error("digit select beyond the last position");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_digit_select_i) && $stable(out_segments_i)))
    else $error("stalled output beat changed");

  a_first_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !seen_q) |-> (out_digit_select_i == '0))
    else $error("scan did not start at position zero");

  a_scan_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && seen_q) |-> (out_digit_select_i == next_sel))
    else $error("scan position skipped or repeated");

  a_seg_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((out_segments_i == 8'hC0) || (out_segments_i == 8'hF9) ||
                     (out_segments_i == 8'hA4) || (out_segments_i == 8'hB0) ||
                     (out_segments_i == 8'h99) || (out_segments_i == 8'h92) ||
                     (out_segments_i == 8'h82) || (out_segments_i == 8'hF8) ||
                     (out_segments_i == 8'h80) || (out_segments_i == 8'h90) ||
                     (out_segments_i == SegBlank)))
    else $error("segment pattern is not a digit or blank");

endmodule

bind seven_segment_decimal_display ssdd_checker #(
  .DIGIT_COUNT(DIGIT_COUNT)
) u_ssdd_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_digit_select_i (out_o.digit_select),
  .out_segments_i     (out_o.segments)
);

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ssdd_pkg::*;

  localparam int unsigned Digits     = DigitCountDefault;
  localparam int unsigned RandBeats  = 1100;
  localparam int unsigned CalmTail   = 150;
  localparam int unsigned HoldStart  = 300;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned Drain      = 4 * (Digits + 2);
  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    op_e     op;
    number_t number;
  } beat_t;

  typedef struct packed {
    logic [SelWidth-1:0] sel;
    seg_t                seg;
  } scan_t;

  logic clk_i;
  logic rst_ni;

  ssdd_in_if  in_if ();
  ssdd_out_if out_if ();

  seven_segment_decimal_display #(
    .DIGIT_COUNT(Digits)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  beat_t pending_beats[$];
  scan_t expected_scan[$];

  seg_t digit_glyph [10] = '{8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99,
                             8'h92, 8'h82, 8'hF8, 8'h80, 8'h90};
  seg_t shown_code [Digits] = '{default: SegBlank};
  logic [SelWidth-1:0] scan_pos = '0;

  int unsigned err_count;
  int unsigned cycle_count;
  int unsigned in_beats;
  int unsigned in_gap;
  int unsigned out_gap;
  int unsigned hold_left;
  logic        hold_done;
  beat_t       next_beat;
  scan_t       want;

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    err_count++;
  endtask

  task automatic queue_beat(input op_e op, input number_t number);
    beat_t b;
    b.op     = op;
    b.number = number;
    pending_beats.push_back(b);
  endtask

  // Loads rewrite the whole buffer; ticks show one position and move the scan on.
  task automatic predict_beat(input beat_t b);
    number_t rest;
    bcd_t    digs [Digits];
    bit      leading;
    scan_t   s;
    if (b.op == OpLoad) begin
      rest = b.number;
      for (int k = 0; k < Digits; k++) begin
        digs[k] = bcd_t'(rest % 10);
        rest    = rest / 10;
      end
      leading = 1'b1;
      for (int k = Digits - 1; k >= 0; k--) begin
        if (leading && k > 0 && digs[k] == 0) begin
          shown_code[k] = SegBlank;
        end else begin
          leading       = 1'b0;
          shown_code[k] = digit_glyph[digs[k]];
        end
      end
    end else begin
      s.sel = scan_pos;
      s.seg = shown_code[scan_pos];
      expected_scan.push_back(s);
      scan_pos = (scan_pos == Digits - 1) ? '0 : scan_pos + 1'b1;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.operation <= OpLoad;
      in_if.number    <= '0;
      in_gap          <= 0;
      in_beats        <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_beat('{op: in_if.operation, number: in_if.number});
        in_beats <= in_beats + 1;
      end
      if (!in_if.valid || in_if.ready) begin
        if (in_gap > 0) begin
          in_gap      <= in_gap - 1;
          in_if.valid <= 1'b0;
        end else if (pending_beats.size() == 0) begin
          in_if.valid <= 1'b0;
        end else if (hold_left == 0 && pending_beats.size() > CalmTail &&
                     $urandom_range(0, 7) == 0) begin
          in_gap      <= $urandom_range(0, 5);
          in_if.valid <= 1'b0;
        end else begin
          next_beat        = pending_beats.pop_front();
          in_if.valid     <= 1'b1;
          in_if.operation <= next_beat.op;
          in_if.number    <= next_beat.number;
        end
      end
    end
  end

  // The long hold-off on the output side, so that the pipeline backs up.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && in_beats >= HoldStart) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      out_gap      <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_scan.size() == 0) begin
          report_mismatch($sformatf("unexpected beat sel=%0d seg=%h",
                                    out_if.digit_select, out_if.segments));
        end else begin
          want = expected_scan.pop_front();
          if (out_if.digit_select !== want.sel) begin
            report_mismatch($sformatf("digit_select %0d, expected %0d",
                                      out_if.digit_select, want.sel));
          end
          if (out_if.segments !== want.seg) begin
            report_mismatch($sformatf("segments %h at position %0d, expected %h",
                                      out_if.segments, want.sel, want.seg));
          end
        end
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap      <= out_gap - 1;
        out_if.ready <= 1'b0;
      end else if (pending_beats.size() > CalmTail && $urandom_range(0, 7) == 0) begin
        out_gap      <= $urandom_range(0, 5);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned count;
    int unsigned span;
    number_t     n;

    rst_ni = 1'b0;

    // The buffer is blank after reset, zero shows as one digit, and wide
    // numbers wrap modulo one million.
    queue_beat(OpTick, 32'h0);
    queue_beat(OpTick, 32'hFFFF_FFFF);
    queue_beat(OpLoad, 32'd0);
    repeat (5) queue_beat(OpTick, 32'h0);
    queue_beat(OpLoad, 32'hFFFF_FFFF);
    repeat (6) queue_beat(OpTick, 32'hFFFF_FFFF);
    queue_beat(OpLoad, 32'd1034817);
    repeat (6) queue_beat(OpTick, 32'h5555_5555);
    queue_beat(OpLoad, 32'd1000000);
    queue_beat(OpTick, 32'hAAAA_AAAA);

    count = 0;
    while (count < RandBeats) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: n = $urandom;
          1: begin
            span = 1;
            repeat ($urandom_range(1, Digits)) span = span * 10;
            n = $urandom_range(0, span - 1);
          end
          2: n = number_t'(1000000) * $urandom_range(0, 4294) + $urandom_range(0, 9);
          default: n = $urandom_range(0, 9);
        endcase
        queue_beat(OpLoad, n);
        count++;
        repeat ($urandom_range(1, 2 * Digits)) begin
          queue_beat(OpTick, $urandom);
          count++;
        end
      end else begin
        queue_beat(OpTick, $urandom);
        count++;
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_beats.size() != 0 || in_if.valid) @(posedge clk_i);
    while (expected_scan.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);

    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
